// ===== hw/rtl/slkt_pkg.sv =====
`default_nettype none
package slkt_pkg;

  localparam int CAPACITY  = 16;
  localparam int KEY_BITS  = 32;
  localparam int DATA_BITS = 32;
  localparam int IDX_W     = $clog2(CAPACITY);
  localparam int CNT_W     = $clog2(CAPACITY + 1);

  typedef enum logic [1:0] {
    MODE_INSERT = 2'd0,
    MODE_REMOVE = 2'd1,
    MODE_FIND   = 2'd2,
    MODE_NOP    = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_BADPOS   = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic [31:0] key;
    logic [31:0] payload;
    logic [3:0]  position;
  } in_beat_t;

  typedef struct packed {
    logic [1:0] status;
    logic [4:0] found_position;
    logic [4:0] entry_count;
  } out_beat_t;

  typedef struct packed {
    logic [KEY_BITS-1:0]  key;
    logic [DATA_BITS-1:0] payload;
  } entry_t;

  typedef struct packed {
    logic                 ins_en;
    logic                 rem_en;
    logic [KEY_BITS-1:0]  key;
    logic [DATA_BITS-1:0] payload;
  } cell_cmd_t;

endpackage
`default_nettype wire

// ===== hw/rtl/slkt_cell.sv =====
`default_nettype none
module slkt_cell
  import slkt_pkg::*;
(
  input  wire logic      clk,
  input  wire cell_cmd_t cmd,
  input  wire logic      occupied,
  input  wire logic      at_or_after_pos,
  input  wire logic      prev_le,
  input  wire entry_t    prev_entry,
  input  wire entry_t    next_entry,
  output entry_t         entry,
  output logic           lt,
  output logic           le
);

  entry_t entry_r;
  entry_t entry_nxt;

  assign entry = entry_r;
  assign lt    = occupied && (entry_r.key < cmd.key);
  assign le    = occupied && (entry_r.key <= cmd.key);

  always_comb begin
    entry_nxt = entry_r;
    if (cmd.ins_en && !le) begin
      if (prev_le) begin
        entry_nxt.key     = cmd.key;
        entry_nxt.payload = cmd.payload;
      end else begin
        entry_nxt = prev_entry;
      end
    end else if (cmd.rem_en && at_or_after_pos) begin
      entry_nxt = next_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule
`default_nettype wire

// ===== hw/rtl/sorted_leaf_key_table.sv =====
`default_nettype none
// channel | ports                        | beat accepted when
// in      | start, busy, in_item         | start && !busy at a rising edge
// out     | out_valid, out_item          | out_valid high for one cycle
//
// Each command is handled in a capture cycle that registers the beat, then
// a compare cycle in which every cell compares its key and shifts in
// parallel. The result strobes in the cycle after the compare cycle, and
// busy is high only during the compare cycle, so no new command is taken
// while it lasts. Reset (rst_n low, sync) empties the table; stored entries
// need no clearing. Results cannot be stalled.
module sorted_leaf_key_table
  import slkt_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     start,
  output logic          busy,
  input  wire in_beat_t in_item,
  output logic          out_valid,
  output out_beat_t     out_item
);

  logic              req_r;
  in_beat_t          cmd_r;
  logic [CNT_W-1:0]  fill_r;
  logic [CNT_W-1:0]  fill_nxt;
  logic              out_valid_r;
  out_beat_t         out_r;
  out_beat_t         out_nxt;

  cell_cmd_t         cell_cmd;
  entry_t            entries [CAPACITY];
  logic [CAPACITY-1:0] lt_vec;
  logic [CAPACITY-1:0] le_vec;
  logic              is_full;
  logic              pos_ok;
  logic [CNT_W-1:0]  lower_bound;
  logic              key_hit;

  assign busy      = req_r;
  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  assign is_full     = (fill_r >= CNT_W'(CAPACITY));
  assign pos_ok      = ({1'b0, cmd_r.position} < fill_r);
  assign lower_bound = CNT_W'($countones(lt_vec));
  assign key_hit     = |(le_vec & ~lt_vec);

  always_comb begin
    cell_cmd.ins_en  = req_r && (mode_t'(cmd_r.mode) == MODE_INSERT) && !is_full;
    cell_cmd.rem_en  = req_r && (mode_t'(cmd_r.mode) == MODE_REMOVE) && pos_ok;
    cell_cmd.key     = cmd_r.key[KEY_BITS-1:0];
    cell_cmd.payload = cmd_r.payload[DATA_BITS-1:0];
  end

  genvar gi;
  generate
    for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
      entry_t prev_e;
      entry_t next_e;
      logic   prev_le_w;
      if (gi == 0) begin : g_first
        assign prev_e    = '0;
        assign prev_le_w = 1'b1;
      end else begin : g_mid
        assign prev_e    = entries[gi-1];
        assign prev_le_w = le_vec[gi-1];
      end
      if (gi == CAPACITY - 1) begin : g_last
        assign next_e = '0;
      end else begin : g_nlast
        assign next_e = entries[gi+1];
      end
      slkt_cell u_cell (
        .clk             (clk),
        .cmd             (cell_cmd),
        .occupied        (CNT_W'(gi) < fill_r),
        .at_or_after_pos (CNT_W'(gi) >= {1'b0, cmd_r.position}),
        .prev_le         (prev_le_w),
        .prev_entry      (prev_e),
        .next_entry      (next_e),
        .entry           (entries[gi]),
        .lt              (lt_vec[gi]),
        .le              (le_vec[gi])
      );
    end
  endgenerate

  always_comb begin
    fill_nxt = fill_r;
    out_nxt  = '0;
    case (mode_t'(cmd_r.mode))
      MODE_INSERT: begin
        out_nxt.found_position = lower_bound;
        if (is_full) begin
          out_nxt.status = ST_FULL;
        end else begin
          fill_nxt = fill_r + CNT_W'(1);
        end
      end
      MODE_REMOVE: begin
        if (pos_ok) begin
          fill_nxt = fill_r - CNT_W'(1);
        end else begin
          out_nxt.status = ST_BADPOS;
        end
      end
      MODE_FIND: begin
        out_nxt.found_position = lower_bound;
        if (!key_hit) begin
          out_nxt.status = ST_NOTFOUND;
        end
      end
      default: begin
        out_nxt.status = ST_OK;
      end
    endcase
    out_nxt.entry_count = fill_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_r       <= 1'b0;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      req_r       <= start && !req_r;
      out_valid_r <= req_r;
      if (req_r) begin
        fill_r <= fill_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !req_r) begin
      cmd_r <= in_item;
    end
    if (req_r) begin
      out_r <= out_nxt;
    end
  end

`ifndef SYNTHESIS
  a_no_overfill: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_strobe_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while busy");

  a_count_tracks: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_item.entry_count == fill_r))
    else $error("reported entry count differs from table");

  a_full_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.status == ST_FULL) |-> (fill_r == CNT_W'(CAPACITY)))
    else $error("full status with free slots");
`endif

endmodule
`default_nettype wire
